[sv/sstb_pkg.sv]
// Shared types and constants for the saturating soft timer bank.
`timescale 1ns / 1ps
`default_nettype none

package sstb_pkg;

  localparam int NUM_TIMERS = 8;
  localparam int TIDX_W     = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
  localparam int COUNT_W    = 32;
  localparam int RES_W      = 16;
  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 40;

  typedef enum logic [2:0] {
    KIND_TICK  = 3'd0,
    KIND_START = 3'd1,
    KIND_STOP  = 3'd2,
    KIND_SET   = 3'd3,
    KIND_READ  = 3'd4
  } kind_t;

  typedef struct packed {
    logic              op_load;    // apply start/stop/set/read, load result
    logic              tick_en;    // step the shared adder on tick_idx
    logic [TIDX_W-1:0] tick_idx;
    logic              tick_done;  // load the zero result of a tick
  } sstb_cmd_t;

  typedef struct packed {
    logic out_free;
  } sstb_status_t;

endpackage

`default_nettype wire

[sv/saturating_soft_timer_bank.sv]
// Top level of the saturating soft timer bank.
`timescale 1ns / 1ps
`default_nettype none

// A bank of NUM_TIMERS 32-bit timers, each running timer counting up (saturating at all
// ones) or down (saturating at zero) by the resolution register on every tick item.
// Every item other than a tick returns the addressed timer's count and running
// flag; start, stop and set first apply their change. A tick is accepted, then steps
// each timer in turn through the shared saturating adder, then a done state loads the
// zero result once the output register is free. Results sit in an output register;
// the input is held off while a result waits, and the next item is taken in
// the cycle that result is accepted. Write resolution only while idle.

module saturating_soft_timer_bank
  import sstb_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  s_axis_tvalid,
  output logic                       s_axis_tready,
  // timer_index[2:0], new_count[34:3], count_up[35], zero pad
  input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,
  // kind[2:0]
  input  wire logic [2:0]            s_axis_tuser,
  output logic                       m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  // count_value[31:0], timer_active[32], zero pad
  output logic [OUT_DATA_W-1:0]      m_axis_tdata,
  input  wire logic                  cfg_we,
  input  wire logic [RES_W-1:0]      cfg_wdata
);

  sstb_cmd_t          cmd;
  sstb_status_t       status;
  logic [COUNT_W-1:0] out_count;
  logic               out_active;

  sstb_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_kind  (s_axis_tuser),
    .in_ready (s_axis_tready),
    .status   (status),
    .cmd      (cmd)
  );

  sstb_datapath u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .status     (status),
    .in_kind    (s_axis_tuser),
    .in_index   (s_axis_tdata[2:0]),
    .in_count   (s_axis_tdata[34:3]),
    .in_up      (s_axis_tdata[35]),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .out_valid  (m_axis_tvalid),
    .out_ready  (m_axis_tready),
    .out_count  (out_count),
    .out_active (out_active)
  );

  assign m_axis_tdata = {{(OUT_DATA_W - COUNT_W - 1){1'b0}}, out_active, out_count};

endmodule

`default_nettype wire

[sv/sstb_ctrl.sv]
// Controller: input handshake and tick sequencer for the timer bank.
`timescale 1ns / 1ps
`default_nettype none

module sstb_ctrl
  import sstb_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         in_valid,
  input  wire logic [2:0]   in_kind,
  output logic              in_ready,
  input  wire sstb_status_t status,
  output sstb_cmd_t         cmd
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_TICK,
    ST_DONE
  } state_t;

  state_t            state;
  logic [TIDX_W-1:0] idx;
  logic              accept;
  logic              is_tick;

  assign is_tick  = (in_kind == KIND_TICK);
  assign in_ready = (state == ST_IDLE) && status.out_free;
  assign accept   = in_valid && in_ready;

  always_comb begin
    cmd.op_load   = accept && !is_tick;
    cmd.tick_en   = (state == ST_TICK);
    cmd.tick_idx  = idx;
    cmd.tick_done = (state == ST_DONE) && status.out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      idx   <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          idx <= '0;
          if (accept && is_tick) state <= ST_TICK;
        end
        ST_TICK: begin
          if (idx == TIDX_W'(NUM_TIMERS - 1)) begin
            state <= ST_DONE;
          end else begin
            idx <= idx + 1'b1;
          end
        end
        ST_DONE: begin
          if (status.out_free) state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

[sv/sstb_datapath.sv]
// Datapath: timer state, shared saturating adder, resolution and result register.
`timescale 1ns / 1ps
`default_nettype none

module sstb_datapath
  import sstb_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire sstb_cmd_t             cmd,
  output sstb_status_t               status,
  input  wire logic [2:0]            in_kind,
  input  wire logic [2:0]            in_index,
  input  wire logic [COUNT_W-1:0]    in_count,
  input  wire logic                  in_up,
  input  wire logic                  cfg_we,
  input  wire logic [RES_W-1:0]      cfg_wdata,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic [COUNT_W-1:0]         out_count,
  output logic                       out_active
);

  logic [COUNT_W-1:0] count [NUM_TIMERS];
  logic               dir   [NUM_TIMERS];
  logic               run   [NUM_TIMERS];
  logic [RES_W-1:0]   resolution;

  // shared saturating adder
  logic [COUNT_W-1:0] t_cur;
  logic [COUNT_W:0]   t_sum;
  logic [COUNT_W:0]   t_diff;
  logic [COUNT_W-1:0] t_next;

  // addressed timer
  logic               in_range;
  logic [TIDX_W-1:0]  a_idx;
  logic [COUNT_W-1:0] a_count;
  logic               a_run;

  assign status.out_free = !out_valid || out_ready;

  always_comb begin
    t_cur  = count[cmd.tick_idx];
    t_sum  = {1'b0, t_cur} + {{(COUNT_W + 1 - RES_W){1'b0}}, resolution};
    t_diff = {1'b0, t_cur} - {{(COUNT_W + 1 - RES_W){1'b0}}, resolution};
    if (dir[cmd.tick_idx]) begin
      t_next = t_sum[COUNT_W] ? {COUNT_W{1'b1}} : t_sum[COUNT_W-1:0];
    end else begin
      t_next = t_diff[COUNT_W] ? '0 : t_diff[COUNT_W-1:0];
    end
  end

  always_comb begin
    in_range = (32'(in_index) < NUM_TIMERS);
    a_idx    = TIDX_W'(in_index);
    a_count  = count[a_idx];
    a_run    = run[a_idx];
    unique case (in_kind)
      KIND_START: a_run   = 1'b1;
      KIND_STOP:  a_run   = 1'b0;
      KIND_SET:   a_count = in_count;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      resolution <= RES_W'(1);
      for (int k = 0; k < NUM_TIMERS; k++) begin
        count[k] <= '0;
        dir[k]   <= 1'b0;
        run[k]   <= 1'b0;
      end
    end else begin
      if (cfg_we) resolution <= cfg_wdata;
      if (cmd.tick_en && run[cmd.tick_idx]) count[cmd.tick_idx] <= t_next;
      if (cmd.op_load && in_range) begin
        count[a_idx] <= a_count;
        run[a_idx]   <= a_run;
        if (in_kind == KIND_SET) dir[a_idx] <= in_up;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.op_load || cmd.tick_done) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op_load) begin
      out_count  <= in_range ? a_count : '0;
      out_active <= in_range && a_run;
    end else if (cmd.tick_done) begin
      out_count  <= '0;
      out_active <= 1'b0;
    end
  end

endmodule

`default_nettype wire

[verif/tb_saturating_soft_timer_bank.sv]
// Testbench for the saturating soft timer bank: table-driven and random items against a predictor.
`timescale 1ns / 1ps

module tb_saturating_soft_timer_bank;
  import sstb_pkg::*;

  localparam logic [2:0] KIND_SPARE_LO  = 3'd5;
  localparam logic [2:0] KIND_SPARE_MID = 3'd6;
  localparam logic [2:0] KIND_SPARE_HI  = 3'd7;
  localparam int         PHASES         = 6;
  localparam int         PHASE_ITEMS    = 125;

  typedef struct packed {
    logic [COUNT_W-1:0] count;
    logic               active;
  } timer_reading_t;

  typedef struct packed {
    logic [2:0]         kind;
    logic [2:0]         idx;
    logic [COUNT_W-1:0] load;
    logic               up;
    logic               pinned;
    logic [COUNT_W-1:0] want_count;
    logic               want_active;
  } stim_row_t;

  logic                  clk           = 1'b0;
  logic                  rst           = 1'b1;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
  logic [2:0]            s_axis_tuser  = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic                  cfg_we        = 1'b0;
  logic [RES_W-1:0]      cfg_wdata     = '0;

  // fixed expectation travelling alongside a directed item
  logic                  pin_on        = 1'b0;
  timer_reading_t        pin_reading   = '0;

  bit                    calm          = 1'b0;
  int                    stall_left    = 0;

  logic [COUNT_W-1:0]    tmr_count   [NUM_TIMERS];
  logic                  tmr_up      [NUM_TIMERS];
  logic                  tmr_running [NUM_TIMERS];
  logic [RES_W-1:0]      tick_step;

  timer_reading_t        pending_readings [$];
  int                    mismatches    = 0;
  int                    checked       = 0;
  int                    sat_moves     = 0;
  int                    settings_used = 0;
  int                    kind_seen [8] = '{default: 0};

  stim_row_t directed_rows [25] = '{
    '{KIND_READ,      3'd0, 32'h0,        1'b0, 1'b1, 32'h0,        1'b0},
    '{KIND_READ,      3'd7, 32'hFFFFFFFF, 1'b1, 1'b1, 32'h0,        1'b0},
    '{KIND_TICK,      3'd0, 32'h0,        1'b0, 1'b1, 32'h0,        1'b0},
    '{KIND_SET,       3'd0, 32'hFFFFFFFF, 1'b1, 1'b1, 32'hFFFFFFFF, 1'b0},
    '{KIND_START,     3'd0, 32'h0,        1'b0, 1'b1, 32'hFFFFFFFF, 1'b1},
    '{KIND_START,     3'd0, 32'h0,        1'b0, 1'b1, 32'hFFFFFFFF, 1'b1},
    '{KIND_TICK,      3'd0, 32'h0,        1'b0, 1'b1, 32'h0,        1'b0},
    '{KIND_READ,      3'd0, 32'h0,        1'b0, 1'b1, 32'hFFFFFFFF, 1'b1},
    '{KIND_SET,       3'd7, 32'h0,        1'b0, 1'b1, 32'h0,        1'b0},
    '{KIND_START,     3'd7, 32'h0,        1'b0, 1'b1, 32'h0,        1'b1},
    '{KIND_TICK,      3'd0, 32'h0,        1'b0, 1'b1, 32'h0,        1'b0},
    '{KIND_READ,      3'd7, 32'h0,        1'b0, 1'b1, 32'h0,        1'b1},
    '{KIND_SET,       3'd3, 32'h5,        1'b0, 1'b1, 32'h5,        1'b0},
    '{KIND_START,     3'd3, 32'h0,        1'b0, 1'b1, 32'h5,        1'b1},
    '{KIND_TICK,      3'd0, 32'h0,        1'b0, 1'b1, 32'h0,        1'b0},
    '{KIND_READ,      3'd3, 32'h0,        1'b0, 1'b1, 32'h4,        1'b1},
    '{KIND_STOP,      3'd3, 32'h0,        1'b0, 1'b1, 32'h4,        1'b0},
    '{KIND_STOP,      3'd3, 32'h0,        1'b0, 1'b1, 32'h4,        1'b0},
    '{KIND_TICK,      3'd0, 32'h0,        1'b0, 1'b1, 32'h0,        1'b0},
    '{KIND_READ,      3'd3, 32'h0,        1'b0, 1'b1, 32'h4,        1'b0},
    '{KIND_SET,       3'd0, 32'h12345678, 1'b0, 1'b1, 32'h12345678, 1'b1},
    '{KIND_SPARE_LO,  3'd0, 32'hFFFFFFFF, 1'b1, 1'b1, 32'h12345678, 1'b1},
    '{KIND_SPARE_MID, 3'd7, 32'h0,        1'b0, 1'b1, 32'h0,        1'b1},
    '{KIND_SPARE_HI,  3'd2, 32'h0,        1'b0, 1'b1, 32'h0,        1'b0},
    '{KIND_SET,       3'd6, 32'hAAAAAAAA, 1'b1, 1'b0, 32'h0,        1'b0}
  };

  saturating_soft_timer_bank i_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata)
  );

  always #2 clk = ~clk;

  initial begin
    #3_000_000;
    $display("end of test: mismatches");
    $finish;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 8);
    return $urandom_range(15, 40);
  endfunction

  function automatic void reset_timers();
    for (int t = 0; t < NUM_TIMERS; t++) begin
      tmr_count[t]   = '0;
      tmr_up[t]      = 1'b0;
      tmr_running[t] = 1'b0;
    end
    tick_step = 16'd1;
  endfunction

  function automatic timer_reading_t advance_timers(input logic [2:0] kind,
                                                    input logic [2:0] idx,
                                                    input logic [COUNT_W-1:0] load,
                                                    input logic up);
    timer_reading_t r;
    logic [COUNT_W:0] moved;
    r = '0;
    if (kind == KIND_TICK) begin
      for (int t = 0; t < NUM_TIMERS; t++) begin
        if (tmr_running[t]) begin
          if (tmr_up[t]) begin
            moved = {1'b0, tmr_count[t]} + {{(COUNT_W + 1 - RES_W){1'b0}}, tick_step};
            if (moved[COUNT_W]) begin
              tmr_count[t] = '1;
              sat_moves++;
            end else begin
              tmr_count[t] = moved[COUNT_W-1:0];
            end
          end else if (tmr_count[t] < tick_step) begin
            tmr_count[t] = '0;
            sat_moves++;
          end else begin
            tmr_count[t] = tmr_count[t] - tick_step;
          end
        end
      end
      return r;
    end
    if (idx >= NUM_TIMERS) return r;
    case (kind)
      KIND_START: tmr_running[idx] = 1'b1;
      KIND_STOP:  tmr_running[idx] = 1'b0;
      KIND_SET: begin
        tmr_count[idx] = load;
        tmr_up[idx]    = up;
      end
      default: ;
    endcase
    r.count  = tmr_count[idx];
    r.active = tmr_running[idx];
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [COUNT_W-1:0] got_v,
                                 input logic [COUNT_W-1:0] want_v);
    if (mismatches < 40) $display("%0t %s: got %h want %h", $time, what, got_v, want_v);
    mismatches++;
  endtask

  always @(posedge clk) begin : scoreboard_p
    timer_reading_t got;
    timer_reading_t want;
    timer_reading_t predicted;
    if (rst) begin
      reset_timers();
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got.count  = m_axis_tdata[COUNT_W-1:0];
        got.active = m_axis_tdata[COUNT_W];
        if (pending_readings.size() == 0) begin
          report_mismatch("result with nothing pending", got.count, '0);
        end else begin
          want = pending_readings.pop_front();
          checked++;
          if (got.count !== want.count) report_mismatch("count_value", got.count, want.count);
          if (got.active !== want.active)
            report_mismatch("timer_active", COUNT_W'(got.active), COUNT_W'(want.active));
        end
      end
      if (cfg_we) tick_step = cfg_wdata;
      if (s_axis_tvalid && s_axis_tready) begin
        predicted = advance_timers(s_axis_tuser, s_axis_tdata[2:0], s_axis_tdata[34:3],
                                   s_axis_tdata[35]);
        kind_seen[s_axis_tuser]++;
        pending_readings.push_back(pin_on ? pin_reading : predicted);
      end
    end
  end

  // result side back-pressure
  always @(posedge clk) begin
    if (stall_left != 0) begin
      m_axis_tready <= 1'b0;
      stall_left    <= stall_left - 1;
    end else if (!calm && $urandom_range(0, 3) == 0) begin
      m_axis_tready <= 1'b0;
      stall_left    <= pick_gap() - 1;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  task automatic send_item(input logic [2:0] kind, input logic [2:0] idx,
                           input logic [COUNT_W-1:0] load, input logic up,
                           input logic pinned, input timer_reading_t pinned_reading);
    int gap;
    gap = (!calm && $urandom_range(0, 2) == 0) ? pick_gap() : 0;
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= kind;
    s_axis_tdata  <= {{(IN_DATA_W - 36){1'b0}}, up, load, idx};
    pin_on        <= pinned;
    pin_reading   <= pinned_reading;
    do @(posedge clk); while (!s_axis_tready);
  endtask

  task automatic send_random(input logic [RES_W-1:0] res);
    int r;
    logic [2:0] kind;
    logic [COUNT_W-1:0] load;
    logic [COUNT_W-1:0] span;
    r = $urandom_range(0, 99);
    if (r < 30)      kind = KIND_TICK;
    else if (r < 45) kind = KIND_START;
    else if (r < 55) kind = KIND_STOP;
    else if (r < 75) kind = KIND_SET;
    else if (r < 90) kind = KIND_READ;
    else             kind = KIND_SPARE_LO + 3'($urandom_range(0, 2));
    // counts close to either rail so a few ticks reach saturation
    span = 4 * res + 3;
    r = $urandom_range(0, 99);
    if (r < 30)      load = $urandom_range(0, span);
    else if (r < 60) load = 32'hFFFFFFFF - $urandom_range(0, span);
    else             load = $urandom;
    send_item(kind, 3'($urandom_range(0, 7)), load, 1'($urandom_range(0, 1)), 1'b0, '0);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk); while (pending_readings.size() != 0);
  endtask

  task automatic load_resolution(input logic [RES_W-1:0] v);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
    settings_used++;
  endtask

  initial begin : stimulus_p
    logic [RES_W-1:0] res_plan [PHASES];
    timer_reading_t row_reading;
    res_plan[0] = 16'hFFFF;
    res_plan[1] = 16'h0000;
    res_plan[2] = RES_W'($urandom_range(2, 65534));
    res_plan[3] = 16'h0001;
    res_plan[4] = RES_W'($urandom_range(1, 16));
    res_plan[5] = RES_W'($urandom_range(256, 4096));
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i]) begin
      row_reading.count  = directed_rows[i].want_count;
      row_reading.active = directed_rows[i].want_active;
      send_item(directed_rows[i].kind, directed_rows[i].idx, directed_rows[i].load,
                directed_rows[i].up, directed_rows[i].pinned, row_reading);
    end
    drain();

    for (int p = 0; p < PHASES; p++) begin
      load_resolution(res_plan[p]);
      calm <= (p == 3);
      repeat (PHASE_ITEMS) send_random(res_plan[p]);
      drain();
    end
    calm <= 1'b0;
    repeat (30) @(posedge clk);

    $display("items %0d: ticks %0d, starts %0d, stops %0d, sets %0d, reads %0d, spare kinds %0d",
             checked, kind_seen[KIND_TICK], kind_seen[KIND_START], kind_seen[KIND_STOP],
             kind_seen[KIND_SET], kind_seen[KIND_READ],
             kind_seen[KIND_SPARE_LO] + kind_seen[KIND_SPARE_MID] + kind_seen[KIND_SPARE_HI]);
    $display("resolution settings %0d (zero and full scale included), saturating moves %0d",
             settings_used, sat_moves);
    if (mismatches == 0 && pending_readings.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
